@@ hdl/psmt_pkg.sv @@
// Shared types and codes for the priority subscriber match table.
// No dependencies.
`default_nettype none
package psmt_pkg;
	localparam logic [1:0] OP_SUB   = 2'd0;
	localparam logic [1:0] OP_UNSUB = 2'd1;
	localparam logic [1:0] OP_PUB   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOSLOT  = 2'd2;
	localparam logic [1:0] ST_BADTYPE = 2'd3;

	localparam int MAX_RESULTS = 32;

	typedef struct packed {
		logic [7:0]  category;
		logic [7:0]  event_id;
		logic [7:0]  priority_v;
		logic [15:0] handle;
	} entry_t;
endpackage
`default_nettype wire

@@ hdl/psmt_mem.sv @@
// Synchronous memory with one write and one registered read port.
// No dependencies.
`default_nettype none
module psmt_mem #(
	parameter int SLOTS = 32,
	parameter int AW = 5,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/priority_subscriber_match_table_top.sv @@
// Top level of the priority subscriber match table: sequencer and memories.
// Depends on psmt_pkg and psmt_mem.
`default_nettype none
// Subscribers live in memories (entry data, next and prev links) chained into
// a priority-ordered list; a registered memory read sets the pace. An item is
// handled one at a time. Subscribe walks the list to its position (a read and
// a check state per entry passed), then links in. Unsubscribe reads its links,
// then rewrites the neighbours. Rejected items (table full, unused slot, bad
// event type) answer without a walk. Publish walks the list to its end or to
// MAX_RESULTS matches, each match giving a transaction on the result side; a
// match is held back until the next one or the end of the walk so that the
// final one carries last; a stalled result side stalls the walk at a match or
// its end. Slot allocation is a priority encode over in-use flip-flops.
module priority_subscriber_match_table_top #(
	parameter int SLOTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  category,
	input  wire logic [7:0]  event_id,
	input  wire logic [7:0]  priority_req,
	input  wire logic [15:0] handle,
	input  wire logic [4:0]  slot,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             matched,
	output logic [4:0]       out_slot,
	output logic [15:0]      out_handle,
	output logic             last
);
	import psmt_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = AW + 1;
	localparam int EW = $bits(entry_t);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SUB_RD, S_SUB_CHK, S_SUB_LINK, S_SUB_FIX,
		S_UN_RD, S_UN_W1, S_UN_W2,
		S_PUB_RD, S_PUB_CHK, S_OUT
	} state_t;

	state_t state_q;
	logic [SLOTS-1:0] used_q;
	logic [LW-1:0] head_q, cur_q, prv_q, nx_q, pv_q;
	logic [AW-1:0] idx_q;
	logic [7:0] cat_q, id_q, prio_q;
	logic [15:0] hdl_q;
	logic [CW-1:0] guard_q;
	logic [5:0] nres_q;
	logic any_q;
	logic [4:0] hold_slot_q;
	logic [15:0] hold_handle_q;

	// Entry / link memories
	logic e_we, n_we, p_we;
	logic [AW-1:0] e_wa, n_wa, p_wa, rd_a;
	entry_t e_wd, e_rd;
	logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;

	psmt_mem #(.SLOTS(SLOTS), .AW(AW), .DW(EW)) u_ent (
		.clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(rd_a), .rdata(e_rd));
	psmt_mem #(.SLOTS(SLOTS), .AW(AW), .DW(LW)) u_nxt (
		.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(rd_a), .rdata(n_rd));
	psmt_mem #(.SLOTS(SLOTS), .AW(AW), .DW(LW)) u_prv (
		.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd));

	// lowest free slot
	logic [AW-1:0] free_idx;
	logic full;
	always_comb begin
		free_idx = '0;
		full = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!used_q[i]) begin
				free_idx = AW'(i);
				full = 1'b0;
			end
	end

	logic walk_ok;
	assign walk_ok = (cur_q != NIL) && (guard_q < CW'(SLOTS));
	logic slot_ok;
	assign slot_ok = (int'(slot) < SLOTS) && used_q[AW'(slot)];

	logic hit;
	assign hit = (e_rd.category == 8'd0) ||
		((e_rd.category == cat_q) && ((e_rd.event_id == id_q) || (e_rd.event_id == 8'd0)));

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		rd_a = cur_q[AW-1:0];
		e_we = 1'b0; e_wa = idx_q; e_wd = '{cat_q, id_q, prio_q, hdl_q};
		n_we = 1'b0; n_wa = idx_q; n_wd = cur_q;
		p_we = 1'b0; p_wa = idx_q; p_wd = prv_q;
		unique case (state_q)
			S_SUB_LINK: begin
				n_we = 1'b1;
				p_we = 1'b1;
			end
			S_SUB_FIX: begin
				n_we = (prv_q != NIL); n_wa = prv_q[AW-1:0]; n_wd = {1'b0, idx_q};
				p_we = (cur_q != NIL); p_wa = cur_q[AW-1:0]; p_wd = {1'b0, idx_q};
			end
			S_UN_RD: rd_a = idx_q;
			S_UN_W2: begin
				n_we = (pv_q != NIL); n_wa = pv_q[AW-1:0]; n_wd = nx_q;
				p_we = (nx_q != NIL); p_wa = nx_q[AW-1:0]; p_wd = pv_q;
			end
			default: ;
		endcase
		if (state_q == S_IDLE && in_valid && in_ready && op == OP_SUB && !full) begin
			e_we = 1'b1;
			e_wa = free_idx;
			e_wd = '{category, event_id, priority_req, handle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			head_q <= NIL;
			out_valid <= 1'b0;
			cur_q <= NIL; prv_q <= NIL; nx_q <= NIL; pv_q <= NIL;
			idx_q <= '0; guard_q <= '0; nres_q <= '0; any_q <= 1'b0;
			hold_slot_q <= '0; hold_handle_q <= '0;
			cat_q <= '0; id_q <= '0; prio_q <= '0; hdl_q <= '0;
			status <= '0; matched <= 1'b0; out_slot <= '0; out_handle <= '0; last <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					cat_q <= category; id_q <= event_id; prio_q <= priority_req;
					hdl_q <= handle;
					cur_q <= head_q; prv_q <= NIL; guard_q <= '0;
					nres_q <= '0; any_q <= 1'b0;
					status <= ST_OK; matched <= 1'b0; out_slot <= '0;
					out_handle <= '0; last <= 1'b1;
					unique case (op)
						OP_SUB: if (full) begin
							status <= ST_FULL; out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							idx_q <= free_idx;
							used_q[free_idx] <= 1'b1;
							state_q <= S_SUB_RD;
						end
						OP_UNSUB: begin
							out_slot <= slot;
							if (!slot_ok) begin
								status <= ST_NOSLOT; out_valid <= 1'b1;
								state_q <= S_OUT;
							end else begin
								idx_q <= AW'(slot);
								state_q <= S_UN_RD;
							end
						end
						OP_PUB: if (category == 8'd0 || event_id == 8'd0) begin
							status <= ST_BADTYPE; out_valid <= 1'b1;
							state_q <= S_OUT;
						end else
							state_q <= S_PUB_RD;
						default: ;
					endcase
				end
				S_SUB_RD: state_q <= walk_ok ? S_SUB_CHK : S_SUB_LINK;
				S_SUB_CHK:
					if (e_rd.priority_v <= prio_q) begin
						prv_q <= cur_q;
						cur_q <= n_rd;
						guard_q <= guard_q + CW'(1);
						state_q <= S_SUB_RD;
					end else
						state_q <= S_SUB_LINK;
				S_SUB_LINK: state_q <= S_SUB_FIX;
				S_SUB_FIX: begin
					if (prv_q == NIL) head_q <= {1'b0, idx_q};
					out_slot <= 5'(idx_q);
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_UN_RD: state_q <= S_UN_W1;
				S_UN_W1: begin
					nx_q <= n_rd; pv_q <= p_rd;
					state_q <= S_UN_W2;
				end
				S_UN_W2: begin
					if (pv_q == NIL) head_q <= nx_q;
					used_q[idx_q] <= 1'b0;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_PUB_RD:
					if (walk_ok && nres_q < 6'(MAX_RESULTS)) begin
						if (out_ready) out_valid <= 1'b0;
						state_q <= S_PUB_CHK;
					end else if (!out_valid || out_ready) begin
						// end of walk: held match goes out as the final one
						matched <= any_q;
						out_slot <= any_q ? hold_slot_q : 5'd0;
						out_handle <= any_q ? hold_handle_q : 16'd0;
						last <= 1'b1;
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end
				S_PUB_CHK:
					if (!hit) begin
						cur_q <= n_rd;
						guard_q <= guard_q + CW'(1);
						if (out_ready) out_valid <= 1'b0;
						state_q <= S_PUB_RD;
					end else if (!out_valid || out_ready) begin
						// a new match releases the one held before it
						cur_q <= n_rd;
						guard_q <= guard_q + CW'(1);
						any_q <= 1'b1;
						nres_q <= nres_q + 6'd1;
						hold_slot_q <= 5'(cur_q[AW-1:0]);
						hold_handle_q <= e_rd.handle;
						out_valid <= any_q;
						matched <= 1'b1; out_slot <= hold_slot_q;
						out_handle <= hold_handle_q; last <= 1'b0;
						state_q <= S_PUB_RD;
					end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
